/* src/baro_pressure_compensation_assert.svh */
// Assertion macros shared by the pressure compensation RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef BARO_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_COMPENSATION_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define BPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define BPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication, checked during reset too.
`define BPC_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

/* src/bpc_pkg.sv */
// Package for the barometric pressure compensation block: field widths,
// register indexes and fixed-point constants. No dependencies.
package bpc_pkg;

  localparam int RAW_W   = 24;
  localparam int COEFF_W = 16;
  localparam int OUT_W   = 24;
  localparam int IDX_W   = 3;

  // Pipeline depth from input transfer to output register.
  localparam int NSTAGES = 9;

  typedef enum logic [IDX_W-1:0] {
    REG_SENS        = 3'd0,
    REG_OFFSET      = 3'd1,
    REG_SENS_TEMP   = 3'd2,
    REG_OFFSET_TEMP = 3'd3,
    REG_REF_TEMP    = 3'd4
  } cfg_reg_t;

  // -1000 mbar folded into the offset term: 100000 * 2^21
  localparam logic signed [41:0] OFFS_BIAS = 42'sd209715200000;

  // floor(x/100) of a signed 26-bit value via a positive bias of 100*335545
  localparam logic signed [27:0] DIV_BIAS   = 28'sd33554500;
  localparam logic signed [21:0] DIV_Q_BIAS = 22'sd335545;

  // ceil(2^34 / 100): exact quotient for dividends below 2^27
  localparam logic [27:0] RECIP       = 28'd171798692;
  localparam int          RECIP_SHIFT = 34;

  localparam logic signed [24:0] OUT_MAX = 25'sd8388607;
  localparam logic signed [24:0] OUT_MIN = -25'sd8388608;

endpackage

/* src/bpc_if.sv */
// Valid/ready channel interfaces for raw conversions and compensated results.
// Depends on bpc_pkg for the field widths.
interface bpc_raw_if import bpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RAW_W-1:0]   pressure_raw;
  logic [RAW_W-1:0]   temperature_raw;

  modport source (output valid, output pressure_raw, output temperature_raw, input ready);
  modport sink   (input valid, input pressure_raw, input temperature_raw, output ready);
endinterface

interface bpc_comp_if import bpc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] pressure_delta;
  logic                    saturated;

  modport source (output valid, output pressure_delta, output saturated, input ready);
  modport sink   (input valid, input pressure_delta, input saturated, output ready);
endinterface

/* src/baro_pressure_compensation.sv */
// An input transfer passes through stages 0 to 8 to reach the output register.
// Throughput: one conversion pair per cycle while comp.ready holds; each stage
// advances when it is empty or the next stage advances; bubbles fill on stall.
// The three multiplier stages set the depth (dT*C3/C4, D1*SENS halves, 1/100).
// Reset (rst, synchronous) clears all stage valid bits and the calibration words.
// Depends on bpc_pkg, bpc_if.sv and baro_pressure_compensation_assert.svh.
`include "baro_pressure_compensation_assert.svh"

module baro_pressure_compensation import bpc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [COEFF_W-1:0]   cfg_data,
  bpc_raw_if.sink              raw,
  bpc_comp_if.source           comp
);

  // calibration words
  logic [COEFF_W-1:0] c1, c2, c3, c4, c5;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      c5 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SENS:        c1 <= cfg_data;
        REG_OFFSET:      c2 <= cfg_data;
        REG_SENS_TEMP:   c3 <= cfg_data;
        REG_OFFSET_TEMP: c4 <= cfg_data;
        REG_REF_TEMP:    c5 <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage load enables
  logic [NSTAGES-1:0] v;
  logic [NSTAGES-1:0] en;

  always_comb begin
    en[NSTAGES-1] = !v[NSTAGES-1] || comp.ready;
    for (int i = NSTAGES - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign raw.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= raw.valid;
      end
      for (int i = 1; i < NSTAGES; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // stage 0: dT = D2 - C5*2^8
  logic [RAW_W-1:0]   d1_0;
  logic signed [24:0] dt_0;
  logic signed [24:0] dt_calc;

  assign dt_calc = $signed({1'b0, raw.temperature_raw}) - $signed({1'b0, c5, 8'h00});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_0 <= raw.pressure_raw;
      dt_0 <= dt_calc;
    end
  end

  // stage 1: temperature products
  logic [RAW_W-1:0]   d1_1;
  logic signed [41:0] pc3_1, pc4_1;
  logic signed [41:0] pc3_calc, pc4_calc;

  assign pc3_calc = dt_0 * $signed({1'b0, c3});
  assign pc4_calc = dt_0 * $signed({1'b0, c4});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_1  <= d1_0;
      pc3_1 <= pc3_calc;
      pc4_1 <= pc4_calc;
    end
  end

  // stage 2: SENS*2^7 and OFF*2^6 with the -1000 mbar bias
  logic [RAW_W-1:0]   d1_2;
  logic signed [41:0] sens_2, offa_2;
  logic signed [41:0] sens_calc, offa_calc;

  assign sens_calc = $signed({1'b0, c1, 23'd0}) + pc3_1;
  assign offa_calc = $signed({1'b0, c2, 23'd0}) + pc4_1 + OFFS_BIAS;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      d1_2   <= d1_1;
      sens_2 <= sens_calc;
      offa_2 <= offa_calc;
    end
  end

  // stage 3: D1 times the high and low halves of SENS (split at bit 22)
  logic [45:0]        rr_3;
  logic signed [44:0] ph_3;
  logic signed [41:0] offa_3;
  logic [45:0]        rr_calc;
  logic signed [44:0] ph_calc;

  assign rr_calc = d1_2 * sens_2[21:0];
  assign ph_calc = $signed({1'b0, d1_2}) * $signed(sens_2[41:22]);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      rr_3   <= rr_calc;
      ph_3   <= ph_calc;
      offa_3 <= offa_2;
    end
  end

  // stage 4: numerator over 2^22, low bits kept as a sticky flag
  logic signed [46:0] fl_4;
  logic               inx_4;
  logic signed [46:0] fl_calc;

  assign fl_calc = ph_3 - offa_3 + $signed({1'b0, rr_3[45:22]});

  always_ff @(posedge clk) begin
    if (en[4]) begin
      fl_4  <= fl_calc;
      inx_4 <= |rr_3[21:0];
    end
  end

  // stage 5: floor by 2^21, then bias to a nonnegative dividend for /100
  logic [26:0]        u_5;
  logic               inx_5;
  logic signed [27:0] u_calc;

  assign u_calc = $signed(fl_4[46:21]) + DIV_BIAS;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      u_5   <= u_calc[26:0];
      inx_5 <= inx_4 | (|fl_4[20:0]);
    end
  end

  // stage 6: reciprocal multiply
  logic [54:0] prod_6;
  logic [26:0] u_6;
  logic        inx_6;
  logic [54:0] prod_calc;

  assign prod_calc = u_5 * RECIP;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      prod_6 <= prod_calc;
      u_6    <= u_5;
      inx_6  <= inx_5;
    end
  end

  // stage 7: unbias the floor quotient, flag a nonzero remainder
  logic signed [21:0] q_7;
  logic               inx_7;
  logic [20:0]        q_u;
  logic [26:0]        rem;
  logic signed [21:0] q_calc;

  assign q_u    = prod_6[54:RECIP_SHIFT];
  assign rem    = u_6 - q_u * 27'd100;
  assign q_calc = $signed({1'b0, q_u}) - DIV_Q_BIAS;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      q_7   <= q_calc;
      inx_7 <= inx_6 | (rem != '0);
    end
  end

  // stage 8: floor to truncation toward zero, saturate
  logic signed [OUT_W-1:0] pd_8;
  logic                    sat_8;
  logic signed [24:0]      res;

  assign res = 25'(q_7) + ((q_7 < 0 && inx_7) ? 25'sd1 : 25'sd0);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      if (res > OUT_MAX) begin
        pd_8  <= OUT_MAX[OUT_W-1:0];
        sat_8 <= 1'b1;
      end else if (res < OUT_MIN) begin
        pd_8  <= OUT_MIN[OUT_W-1:0];
        sat_8 <= 1'b1;
      end else begin
        pd_8  <= res[OUT_W-1:0];
        sat_8 <= 1'b0;
      end
    end
  end

  assign comp.valid          = v[NSTAGES-1];
  assign comp.pressure_delta = pd_8;
  assign comp.saturated      = sat_8;

  `BPC_ASSERT_IMP(a_ready_when_drained, !v[NSTAGES-1], raw.ready, "input stalled with empty output")
  `BPC_ASSERT_NXT(a_entry_valid, raw.valid && raw.ready, v[0], "transfer lost at pipeline entry")
  `BPC_ASSERT_IMP(a_sat_at_limit, comp.valid && comp.saturated, (comp.pressure_delta == OUT_MAX[OUT_W-1:0]) || (comp.pressure_delta == OUT_MIN[OUT_W-1:0]), "saturated result not at a limit")
  `BPC_ASSERT_ALWAYS(a_reset_empty, $past(rst), !comp.valid, "output valid right after reset")

endmodule

/* tb/sv/bpc_tb_pkg.sv */
// Result store and pressure predictor for the pressure compensation testbench.
// Depends on bpc_pkg for widths, register indexes and output limits.
package bpc_tb_pkg;
  import bpc_pkg::*;

  localparam int     REG_COUNT      = 5;
  localparam longint REF_TEMP_SCALE = 64'sd256;
  localparam longint SENS_SCALE     = 64'sd8388608;              // 2^23
  localparam int     OFFS_SHIFT     = 22;
  localparam longint P_DIVISOR      = 64'sd879609302220800;      // 100 * 2^43
  localparam longint P_BIAS         = 64'sd879609302220800000;   // 1000 mbar at that scale

  typedef struct packed {
    logic signed [OUT_W-1:0] delta;
    logic                    sat;
  } pressure_result_t;

  class pressure_scoreboard;
    logic [COEFF_W-1:0] coeff [REG_COUNT];
    pressure_result_t   pending_pressure [$];
    int                 mismatches;
    int                 results_seen;

    function new();
      foreach (coeff[k]) coeff[k] = '0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // Track a calibration write; unused indexes leave the words alone.
    function void load_coeff(input logic [IDX_W-1:0] index, input logic [COEFF_W-1:0] value);
      case (index)
        REG_SENS, REG_OFFSET, REG_SENS_TEMP, REG_OFFSET_TEMP, REG_REF_TEMP: begin
          coeff[index] = value;
        end
        default: ;
      endcase
    endfunction

    // Whole expression in wide integers, one signed division truncating toward zero.
    function pressure_result_t compensate(input logic [RAW_W-1:0] d1,
                                          input logic [RAW_W-1:0] d2);
      longint            dt;
      longint            sens;
      longint            offs;
      logic signed [95:0] d1_w;
      logic signed [95:0] sens_w;
      logic signed [95:0] offs_w;
      logic signed [95:0] num;
      logic signed [95:0] quot;
      pressure_result_t  r;
      dt     = longint'(d2) - longint'(coeff[REG_REF_TEMP]) * REF_TEMP_SCALE;
      sens   = longint'(coeff[REG_SENS]) * SENS_SCALE + dt * longint'(coeff[REG_SENS_TEMP]);
      offs   = longint'(coeff[REG_OFFSET]) * SENS_SCALE + dt * longint'(coeff[REG_OFFSET_TEMP]);
      d1_w   = d1;
      sens_w = sens;
      offs_w = offs;
      num    = d1_w * sens_w - (offs_w <<< OFFS_SHIFT) - P_BIAS;
      quot   = num / P_DIVISOR;
      r.sat  = 1'b0;
      if (quot > OUT_MAX) begin
        r.delta = OUT_W'(OUT_MAX);
        r.sat   = 1'b1;
      end else if (quot < OUT_MIN) begin
        r.delta = OUT_W'(OUT_MIN);
        r.sat   = 1'b1;
      end else begin
        r.delta = quot[OUT_W-1:0];
      end
      return r;
    endfunction

    function void note_conversion(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
      pending_pressure.push_back(compensate(d1, d2));
    endfunction

    function void check_result(input logic signed [OUT_W-1:0] delta, input logic sat);
      pressure_result_t want;
      results_seen++;
      if (pending_pressure.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing pending, pressure_delta %0d saturated %0b",
                 $time, delta, sat);
        return;
      end
      want = pending_pressure.pop_front();
      if (delta !== want.delta) begin
        mismatches++;
        $display("%0t: pressure_delta expected %0d actual %0d", $time, want.delta, delta);
      end
      if (sat !== want.sat) begin
        mismatches++;
        $display("%0t: saturated expected %0b actual %0b", $time, want.sat, sat);
      end
    endfunction
  endclass

endpackage

/* tb/sv/tb_baro_pressure_compensation.sv */
// Testbench top for baro_pressure_compensation: drives conversion pairs and
// calibration words, checks every result. Depends on bpc_pkg, bpc_if.sv, bpc_tb_pkg.
module tb_baro_pressure_compensation;
  import bpc_pkg::*;
  import bpc_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_SETS  = 6;
  localparam int SET_ITEMS    = 125;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_RUNS} stall_mode_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_index;
  logic [COEFF_W-1:0] cfg_data;

  bpc_raw_if  raw_ch ();
  bpc_comp_if comp_ch ();

  baro_pressure_compensation DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .raw       (raw_ch),
    .comp      (comp_ch)
  );

  pressure_scoreboard sb = new();

  int burst_left = 0;
  int sets_loaded = 0;
  int pairs_sent = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Output stall pattern: always ready, coin flips, or runs of stalls.
  initial begin
    stall_mode_t mode;
    int          mode_left;
    int          run_left;
    logic        level;
    mode      = STALL_NONE;
    mode_left = 0;
    run_left  = 0;
    level     = 1'b1;
    comp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = stall_mode_t'($urandom_range(STALL_NONE, STALL_RUNS));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      case (mode)
        STALL_NONE: comp_ch.ready <= 1'b1;
        STALL_COIN: comp_ch.ready <= 1'($urandom_range(0, 1));
        default: begin
          if (run_left == 0) begin
            level    = ~level;
            run_left = level ? $urandom_range(1, 8) : $urandom_range(1, 20);
          end
          run_left--;
          comp_ch.ready <= level;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && comp_ch.valid && comp_ch.ready)
      sb.check_result(comp_ch.pressure_delta, comp_ch.saturated);
  end

  // Write all five words, plus stray writes to the unused indexes.
  task automatic load_calibration(input logic [COEFF_W-1:0] c1, input logic [COEFF_W-1:0] c2,
                                  input logic [COEFF_W-1:0] c3, input logic [COEFF_W-1:0] c4,
                                  input logic [COEFF_W-1:0] c5);
    logic [COEFF_W-1:0] words [REG_COUNT];
    logic [COEFF_W-1:0] value;
    words = '{c1, c2, c3, c4, c5};
    cfg_we <= 1'b1;
    for (int idx = 0; idx < (1 << IDX_W); idx++) begin
      value = (idx < REG_COUNT) ? words[idx] : COEFF_W'($urandom);
      cfg_index <= IDX_W'(idx);
      cfg_data  <= value;
      @(posedge clk);
      sb.load_coeff(IDX_W'(idx), value);
    end
    cfg_we <= 1'b0;
    sets_loaded++;
  endtask

  task automatic send_conversion(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    int gap_len;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
      gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap_len > 0) begin
        raw_ch.valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left--;
    raw_ch.valid           <= 1'b1;
    raw_ch.pressure_raw    <= d1;
    raw_ch.temperature_raw <= d2;
    do @(posedge clk); while (!raw_ch.ready);
    sb.note_conversion(d1, d2);
    pairs_sent++;
  endtask

  // Hold off the sender until the pipeline has drained.
  task automatic settle();
    raw_ch.valid <= 1'b0;
    while (sb.pending_pressure.size() != 0) @(posedge clk);
    repeat (NSTAGES + 2) @(posedge clk);
  endtask

  function automatic logic [COEFF_W-1:0] rand_coeff();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return COEFF_W'($urandom);
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] rand_raw();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {4'hF, 20'($urandom)};
      3:       return RAW_W'($urandom_range(0, 4095));
      default: return RAW_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [RAW_W-1:0] top;
    top = '1;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    raw_ch.valid           <= 1'b0;
    raw_ch.pressure_raw    <= '0;
    raw_ch.temperature_raw <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Calibration left at reset: every pair gives exactly -1000.
    send_conversion('0, '0);
    send_conversion(top, top);
    send_conversion(top, '0);
    send_conversion('0, top);
    settle();

    load_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464);
    send_conversion(24'd9085466, 24'd8569150);
    send_conversion('0, '0);
    send_conversion(top, top);
    send_conversion('0, top);
    send_conversion(top, '0);
    settle();

    load_calibration('1, '1, '1, '1, '1);
    send_conversion('0, '0);
    send_conversion(top, top);
    send_conversion(top, '0);
    send_conversion('0, top);
    settle();

    // Sensitivity and offset driven by temperature alone, most negative dT.
    load_calibration('0, '0, '1, '1, '1);
    send_conversion(top, '0);
    send_conversion(24'd1, '0);
    send_conversion(top, top);
    send_conversion(24'h800000, 24'h123456);
    settle();

    // Results just above -1000: truncation must move toward zero.
    load_calibration(16'd1, '0, '0, '0, '0);
    send_conversion(top, '0);
    send_conversion('0, '0);
    send_conversion(24'd1, top);
    settle();

    for (int set = 0; set < RANDOM_SETS; set++) begin
      load_calibration(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff());
      for (int n = 0; n < SET_ITEMS; n++) begin
        send_conversion(rand_raw(), rand_raw());
        if ((set == 1 && n == 60) || $urandom_range(0, 199) == 0)
          settle();
      end
      settle();
    end

    $display("checked %0d results from %0d conversion pairs over %0d calibration sets",
             sb.results_seen, pairs_sent, sets_loaded);
    $display("random sets mixed extreme, zero and full-range words and conversions");
    if (sb.mismatches == 0 && sb.pending_pressure.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
